// File: sv/ssc_pkg.sv
// shared types, constants and the arctangent table of the steering controller
// no dependencies
package ssc_pkg;

   localparam int PI_Q13       = 25736;
   localparam int TWO_PI_Q13   = 51472;
   localparam int PI_Q16       = 205887;
   localparam int CORDIC_STEPS = 17;
   localparam int SQRT_STEPS   = 25;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_STEER = 1'b1;

   localparam logic REG_GAIN     = 1'b0;
   localparam logic REG_PATH_LEN = 1'b1;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [15:0] h;
   } point_type;

   function automatic logic [16:0] atan_q16(input logic [4:0] i);
      logic [16:0] v;
      case (i)
         5'd0:    v = 17'd51472;
         5'd1:    v = 17'd30386;
         5'd2:    v = 17'd16055;
         5'd3:    v = 17'd8150;
         5'd4:    v = 17'd4091;
         5'd5:    v = 17'd2047;
         5'd6:    v = 17'd1024;
         5'd7:    v = 17'd512;
         5'd8:    v = 17'd256;
         5'd9:    v = 17'd128;
         5'd10:   v = 17'd64;
         5'd11:   v = 17'd32;
         5'd12:   v = 17'd16;
         5'd13:   v = 17'd8;
         5'd14:   v = 17'd4;
         5'd15:   v = 17'd2;
         5'd16:   v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

// File: sv/ssc_req_if.sv
// request channel of the steering controller
// depends on nothing
interface ssc_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [9:0]         point_index;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic signed [15:0] angle;
   logic signed [15:0] speed;

   modport source (output valid, opcode, point_index, pos_x, pos_y, angle, speed,
                   input ready);
   modport sink (input valid, opcode, point_index, pos_x, pos_y, angle, speed,
                 output ready);
endinterface

// File: sv/ssc_rsp_if.sv
// response channel of the steering controller
// depends on nothing
interface ssc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] steer_angle;
   logic [9:0]         target_index;
   logic               empty_path;

   modport source (output valid, steer_angle, target_index, empty_path, input ready);
   modport sink (input valid, steer_angle, target_index, empty_path, output ready);
endinterface

// File: sv/stanley_steering_controller_unit.sv
// Stanley path tracking steering controller. A path point write (opcode 0) gives no
// response. A steering request (opcode 1) scans the first n path points
// (n = min(path_length, MAX_POINTS)) over the single memory read port, one point per
// cycle, followed by a drain of the read pipeline, then a square root, the setup states
// ST_SIGN and ST_MULT, an atan2 (normalization, 17 cordic steps and a handoff), a wrap
// of the angle into range and the output state. An empty path goes from idle straight
// to the output state. Once the response is registered, the unit returns to idle and
// takes the next transaction. Only one transaction is in work at a time; a finished
// response waits in an output register.
// depends on ssc_pkg, ssc_req_if, ssc_rsp_if, ssc_path_store, ssc_isqrt, ssc_cordic
module stanley_steering_controller_unit
   import ssc_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   ssc_req_if.sink     req,
   ssc_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int LW = (CW > 11) ? CW : 11;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_MULT = 3'd4;
   localparam logic [2:0] ST_ATAN = 3'd5;
   localparam logic [2:0] ST_WRAP = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [15:0]        gain_ff, gain_in;
   logic [10:0]        plen_ff, plen_in;
   logic signed [23:0] px_ff, px_in, py_ff, py_in;
   logic signed [15:0] ang_ff, ang_in, spd_ff, spd_in;
   logic [CW-1:0]      n_ff, n_in, issue_ff, issue_in;
   logic               empty_ff, empty_in;

   logic               s1_v_ff, s1_v_in;
   logic [AW-1:0]      s1_idx_ff, s1_idx_in;
   logic               s2_v_ff, s2_v_in;
   logic [AW-1:0]      s2_idx_ff, s2_idx_in;
   logic signed [24:0] s2_dx_ff, s2_dx_in, s2_dy_ff, s2_dy_in;
   logic signed [15:0] s2_hd_ff, s2_hd_in;
   logic               s3_v_ff, s3_v_in;
   logic [AW-1:0]      s3_idx_ff, s3_idx_in;
   logic signed [24:0] s3_dx_ff, s3_dx_in, s3_dy_ff, s3_dy_in;
   logic signed [15:0] s3_hd_ff, s3_hd_in;
   logic [49:0]        s3_d_ff, s3_d_in;

   logic               best_set_ff, best_set_in;
   logic [49:0]        best_d_ff, best_d_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic signed [24:0] best_dx_ff, best_dx_in, best_dy_ff, best_dy_in;
   logic signed [15:0] best_hd_ff, best_hd_in;

   logic signed [25:0] e_ff, e_in;
   logic signed [42:0] yv_ff, yv_in;
   logic signed [26:0] xv_ff, xv_in;
   logic signed [19:0] steer_ff, steer_in;

   logic               rsp_v_ff, rsp_v_in;
   logic signed [15:0] rsp_steer_ff, rsp_steer_in;
   logic [9:0]         rsp_idx_ff, rsp_idx_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               req_acc, csr_wr, mem_we, rd_en, in_range;
   logic [LW-1:0]      pidx_w, plen_w, max_w, n_c;
   point_type          wr_pt, rd_pt;
   logic signed [24:0] dx_c, dy_c;
   logic signed [49:0] sqx, sqy;
   logic signed [40:0] lhs, rhs;
   logic signed [42:0] ymul;
   logic signed [19:0] st_c;
   logic [31:0]        idx_w;
   logic               sqrt_start, sqrt_done, cordic_start, cordic_done;
   logic [24:0]        sqrt_root;
   logic signed [17:0] cordic_angle;

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_acc    = req.valid & req.ready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_GAIN) ? {16'd0, gain_ff} : {21'd0, plen_ff};

   assign pidx_w   = LW'(req.point_index);
   assign max_w    = LW'(MAX_POINTS);
   assign plen_w   = LW'(plen_ff);
   assign n_c      = (plen_w > max_w) ? max_w : plen_w;
   assign in_range = pidx_w < max_w;
   assign mem_we   = req_acc & (req.opcode == OP_WRITE) & in_range;
   assign wr_pt    = '{x: req.pos_x, y: req.pos_y, h: req.angle};
   assign rd_en    = (state_ff == ST_SCAN) && (issue_ff < n_ff);

   ssc_path_store #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (pidx_w[AW-1:0]),
      .wr_data (wr_pt),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd_pt)
   );

   ssc_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (best_d_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   ssc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .y_in  (yv_ff),
      .x_in  (xv_ff),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   assign dx_c  = px_ff - rd_pt.x;
   assign dy_c  = py_ff - rd_pt.y;
   assign sqx   = s2_dx_ff * s2_dx_ff;
   assign sqy   = s2_dy_ff * s2_dy_ff;
   assign lhs   = best_dx_ff * best_hd_ff;
   assign rhs   = best_dy_ff <<< 13;
   assign ymul  = $signed({1'b0, gain_ff}) * e_ff;
   assign st_c  = cordic_angle + best_hd_ff - ang_ff;
   assign idx_w = 32'(best_idx_ff);

   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      plen_in      = plen_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ang_in       = ang_ff;
      spd_in       = spd_ff;
      n_in         = n_ff;
      issue_in     = issue_ff;
      empty_in     = empty_ff;
      s1_v_in      = rd_en;
      s1_idx_in    = issue_ff[AW-1:0];
      s2_v_in      = s1_v_ff;
      s2_idx_in    = s1_idx_ff;
      s2_dx_in     = dx_c;
      s2_dy_in     = dy_c;
      s2_hd_in     = rd_pt.h;
      s3_v_in      = s2_v_ff;
      s3_idx_in    = s2_idx_ff;
      s3_dx_in     = s2_dx_ff;
      s3_dy_in     = s2_dy_ff;
      s3_hd_in     = s2_hd_ff;
      s3_d_in      = 50'(sqx) + 50'(sqy);
      best_set_in  = best_set_ff;
      best_d_in    = best_d_ff;
      best_idx_in  = best_idx_ff;
      best_dx_in   = best_dx_ff;
      best_dy_in   = best_dy_ff;
      best_hd_in   = best_hd_ff;
      e_in         = e_ff;
      yv_in        = yv_ff;
      xv_in        = xv_ff;
      steer_in     = steer_ff;
      rsp_v_in     = rsp_v_ff & ~rsp.ready;
      rsp_steer_in = rsp_steer_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_empty_in = rsp_empty_ff;
      sqrt_start   = 1'b0;
      cordic_start = 1'b0;

      if (csr_wr) begin
         if (csr_paddr[2] == REG_GAIN) begin
            gain_in = csr_pwdata[15:0];
         end else begin
            plen_in = csr_pwdata[10:0];
         end
      end

      if (s3_v_ff && (!best_set_ff || s3_d_ff < best_d_ff)) begin
         best_set_in = 1'b1;
         best_d_in   = s3_d_ff;
         best_idx_in = s3_idx_ff;
         best_dx_in  = s3_dx_ff;
         best_dy_in  = s3_dy_ff;
         best_hd_in  = s3_hd_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req.opcode == OP_STEER) begin
               px_in       = req.pos_x;
               py_in       = req.pos_y;
               ang_in      = req.angle;
               spd_in      = req.speed;
               n_in        = n_c[CW-1:0];
               issue_in    = '0;
               best_set_in = 1'b0;
               empty_in    = (n_c == '0);
               state_in    = (n_c == '0) ? ST_OUT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + CW'(1);
            end else if (!s1_v_ff && !s2_v_ff && !s3_v_ff) begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               e_in     = $signed({1'b0, sqrt_root});
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            yv_in    = (lhs > rhs) ? ymul : -ymul;
            xv_in    = 27'(spd_ff) <<< 10;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            cordic_start = 1'b1;
            state_in     = ST_ATAN;
         end
         ST_ATAN: begin
            if (cordic_done) begin
               steer_in = st_c;
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            if (steer_ff > PI_Q13) begin
               steer_in = 20'(steer_ff - TWO_PI_Q13);
            end else if (steer_ff < -PI_Q13) begin
               steer_in = 20'(steer_ff + TWO_PI_Q13);
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_v_ff || rsp.ready) begin
               rsp_v_in = 1'b1;
               if (empty_ff) begin
                  rsp_steer_in = '0;
                  rsp_idx_in   = '0;
                  rsp_empty_in = 1'b1;
               end else begin
                  rsp_steer_in = steer_ff[15:0];
                  rsp_idx_in   = idx_w[9:0];
                  rsp_empty_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gain_ff  <= 16'd256;
         plen_ff  <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gain_ff  <= gain_in;
         plen_ff  <= plen_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         rsp_v_ff <= rsp_v_in;
      end
      px_ff        <= px_in;
      py_ff        <= py_in;
      ang_ff       <= ang_in;
      spd_ff       <= spd_in;
      n_ff         <= n_in;
      issue_ff     <= issue_in;
      empty_ff     <= empty_in;
      s1_idx_ff    <= s1_idx_in;
      s2_idx_ff    <= s2_idx_in;
      s2_dx_ff     <= s2_dx_in;
      s2_dy_ff     <= s2_dy_in;
      s2_hd_ff     <= s2_hd_in;
      s3_idx_ff    <= s3_idx_in;
      s3_dx_ff     <= s3_dx_in;
      s3_dy_ff     <= s3_dy_in;
      s3_hd_ff     <= s3_hd_in;
      s3_d_ff      <= s3_d_in;
      best_set_ff  <= best_set_in;
      best_d_ff    <= best_d_in;
      best_idx_ff  <= best_idx_in;
      best_dx_ff   <= best_dx_in;
      best_dy_ff   <= best_dy_in;
      best_hd_ff   <= best_hd_in;
      e_ff         <= e_in;
      yv_ff        <= yv_in;
      xv_ff        <= xv_in;
      steer_ff     <= steer_in;
      rsp_steer_ff <= rsp_steer_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp.valid        = rsp_v_ff;
   assign rsp.steer_angle  = rsp_steer_ff;
   assign rsp.target_index = rsp_idx_ff;
   assign rsp.empty_path   = rsp_empty_ff;

endmodule

// File: sv/ssc_path_store.sv
// path point memory, one write and one registered read port
// depends on ssc_pkg
module ssc_path_store
   import ssc_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  point_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output point_type     rd_data
);

   point_type mem [DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ssc_isqrt.sv
// floor square root, one result bit per cycle
// depends on ssc_pkg
module ssc_isqrt
   import ssc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [49:0] radicand,
   output logic        done,
   output logic [24:0] root
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [49:0] rad_ff, rad_in;
   logic [26:0] rem_ff, rem_in;
   logic [24:0] root_ff, root_in;
   logic [28:0] rem_t;
   logic [28:0] trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_t   = {rem_ff[26:0], rad_ff[49:48]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = 5'(SQRT_STEPS);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (run_ff) begin
         if (rem_t >= trial) begin
            rem_in  = 27'(rem_t - trial);
            root_in = {root_ff[23:0], 1'b1};
         end else begin
            rem_in  = rem_t[26:0];
            root_in = {root_ff[23:0], 1'b0};
         end
         rad_in = {rad_ff[47:0], 2'b00};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: sv/ssc_cordic.sv
// atan2 by normalization and cordic vectoring, one step per cycle
// depends on ssc_pkg
module ssc_cordic
   import ssc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [42:0] y_in,
   input  logic signed [26:0] x_in,
   output logic               done,
   output logic signed [17:0] angle
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_NORM = 2'd1;
   localparam logic [1:0] ST_ITER = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   localparam logic signed [47:0] NORM_LIM = 48'sh0100_0000_0000;

   logic [1:0]         state_ff, state_in;
   logic               done_ff, done_in;
   logic signed [47:0] x_ff, x_in_r, y_ff, y_in_r;
   logic signed [19:0] z_ff, z_in;
   logic signed [19:0] base_ff, base_in;
   logic [4:0]         i_ff, i_in;
   logic signed [17:0] angle_ff, angle_in;
   logic signed [47:0] xs, ys, ay, mx, xsh, ysh;
   logic signed [19:0] at;
   logic signed [20:0] sum;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      x_in_r   = x_ff;
      y_in_r   = y_ff;
      z_in     = z_ff;
      base_in  = base_ff;
      i_in     = i_ff;
      angle_in = angle_ff;
      xs       = x_in;
      ys       = y_in;
      ay       = (y_ff < 0) ? -y_ff : y_ff;
      mx       = (x_ff > ay) ? x_ff : ay;
      xsh      = x_ff >>> i_ff;
      ysh      = y_ff >>> i_ff;
      at       = $signed({3'b000, atan_q16(i_ff)});
      sum      = 21'(base_ff) + 21'(z_ff) + 21'sd4;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (x_in == 0 && y_in == 0) begin
                  angle_in = '0;
                  done_in  = 1'b1;
               end else begin
                  if (x_in < 0) begin
                     x_in_r  = -xs;
                     y_in_r  = -ys;
                     base_in = (y_in >= 0) ? 20'(PI_Q16) : -20'(PI_Q16);
                  end else begin
                     x_in_r  = xs;
                     y_in_r  = ys;
                     base_in = '0;
                  end
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (mx < NORM_LIM) begin
               x_in_r = x_ff <<< 1;
               y_in_r = y_ff <<< 1;
            end else begin
               z_in     = '0;
               i_in     = '0;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            if (y_ff >= 0) begin
               x_in_r = x_ff + ysh;
               y_in_r = y_ff - xsh;
               z_in   = z_ff + at;
            end else begin
               x_in_r = x_ff - ysh;
               y_in_r = y_ff + xsh;
               z_in   = z_ff - at;
            end
            i_in = i_ff + 5'd1;
            if (i_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            angle_in = 18'(sum >>> 3);
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff     <= x_in_r;
      y_ff     <= y_in_r;
      z_ff     <= z_in;
      base_ff  <= base_in;
      i_ff     <= i_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

// File: tb/tb_stanley_steering_controller_unit.sv
// testbench of the stanley steering controller: directed table, then random path and
// steering transactions, each response checked against an in-bench path tracking model
// depends on ssc_pkg, ssc_req_if, ssc_rsp_if and stanley_steering_controller_unit
module tb_stanley_steering_controller_unit;
   import ssc_pkg::*;

   localparam int NPTS = 1024;
   localparam int FILL_PTS = 64;
   localparam int WATCHDOG_LIMIT = 400000;

   typedef struct {
      logic               opcode;
      logic [9:0]         point_index;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [15:0] angle;
      logic signed [15:0] speed;
      bit                 typed;
      logic signed [15:0] exp_steer;
      logic [9:0]         exp_index;
      logic               exp_empty;
   } steer_row_type;

   typedef struct {
      logic signed [15:0] steer;
      logic [9:0]         index;
      logic               empty;
   } steer_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   ssc_req_if req ();
   ssc_rsp_if rsp ();

   stanley_steering_controller_unit i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   logic signed [23:0] mdl_x [NPTS];
   logic signed [23:0] mdl_y [NPTS];
   logic signed [15:0] mdl_h [NPTS];
   logic [15:0]        mdl_gain;
   logic [10:0]        mdl_len;
   steer_cmd_type      pending_cmds[$];
   int errors = 0, n_steer = 0, n_write = 0, n_empty = 0, idle_cycles = 0;
   int rsp_gap = 0;
   bit rsp_stall_en = 1'b1, hold_long = 1'b0, done = 1'b0;

   initial begin
      req.valid = 1'b0; req.opcode = OP_WRITE; req.point_index = '0; req.pos_x = '0;
      req.pos_y = '0; req.angle = '0; req.speed = '0;
      rsp.ready = 1'b0;
   end

   function automatic longint asr_f(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint root_floor(longint unsigned n);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint base = 0, z = 0, m, ay, xo;
      longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
                          64, 32, 16, 8, 4, 2, 1};
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         base = (y >= 0) ? PI_Q16 : -PI_Q16;
         x = -x;
         y = -y;
      end
      ay = (y < 0) ? -y : y;
      m = (x > ay) ? x : ay;
      while (m < (64'sd1 <<< 40)) begin
         m *= 2; x *= 2; y *= 2;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xo = x;
         if (y >= 0) begin
            x += asr_f(y, i); y -= asr_f(xo, i); z += tab[i];
         end else begin
            x -= asr_f(y, i); y += asr_f(xo, i); z -= tab[i];
         end
      end
      return asr_f(base + z + 4, 3);
   endfunction

   function automatic steer_cmd_type track_path(steer_row_type r);
      steer_cmd_type c;
      int n = (mdl_len > NPTS) ? NPTS : mdl_len;
      int best = 0;
      longint dx, dy, hd, e, st;
      longint unsigned d, best_d = 0;
      c.steer = '0; c.index = '0; c.empty = 1'b1;
      if (n == 0) return c;
      for (int i = 0; i < n; i++) begin
         dx = longint'(r.pos_x) - mdl_x[i];
         dy = longint'(r.pos_y) - mdl_y[i];
         d = longint'(dx * dx) + longint'(dy * dy);
         if (i == 0 || d < best_d) begin
            best_d = d; best = i;
         end
      end
      dx = longint'(r.pos_x) - mdl_x[best];
      dy = longint'(r.pos_y) - mdl_y[best];
      hd = mdl_h[best];
      e = root_floor(best_d);
      if (!(dx * hd > dy * 8192)) e = -e;
      st = vector_angle(longint'(mdl_gain) * e, longint'(r.speed) * 1024) + hd
           - longint'(r.angle);
      while (st > PI_Q13) st -= TWO_PI_Q13;
      while (st < -PI_Q13) st += TWO_PI_Q13;
      c.steer = st[15:0]; c.index = best[9:0]; c.empty = 1'b0;
      return c;
   endfunction

   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (reg_sel == REG_GAIN) mdl_gain = value[15:0];
      else mdl_len = value[10:0];
   endtask

   task automatic drain_and_settle();
      req.valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic send_item(steer_row_type r, input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req.valid <= 1'b1; req.opcode <= r.opcode; req.point_index <= r.point_index;
      req.pos_x <= r.pos_x; req.pos_y <= r.pos_y; req.angle <= r.angle;
      req.speed <= r.speed;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (r.opcode == OP_WRITE) begin
         n_write++;
         mdl_x[r.point_index] = r.pos_x; mdl_y[r.point_index] = r.pos_y;
         mdl_h[r.point_index] = r.angle;
      end else begin
         steer_cmd_type c;
         c = track_path(r);
         if (r.typed) begin
            c.steer = r.exp_steer; c.index = r.exp_index; c.empty = r.exp_empty;
         end
         pending_cmds = {pending_cmds, c};
         n_steer++;
         if (c.empty) n_empty++;
      end
   endtask

   function automatic steer_row_type mk(logic op, int idx, int x, int y, int a, int s);
      steer_row_type r;
      r.opcode = op; r.point_index = idx[9:0]; r.pos_x = x[23:0]; r.pos_y = y[23:0];
      r.angle = a[15:0]; r.speed = s[15:0]; r.typed = 1'b0;
      r.exp_steer = '0; r.exp_index = '0; r.exp_empty = 1'b0;
      return r;
   endfunction

   function automatic int rnd_pos(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // response side: random stall bursts and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (hold_long) rsp.ready <= 1'b0;
      else if (rsp_gap > 0) begin
         rsp.ready <= 1'b0;
         rsp_gap   <= rsp_gap - 1;
      end else if (rsp_stall_en && $urandom_range(0, 5) == 0) begin
         rsp.ready <= 1'b0;
         rsp_gap   <= $urandom_range(0, 9);
      end else rsp.ready <= 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_cmds.size() == 0) begin
            $error("response with no steering request outstanding");
            errors++;
         end else begin
            steer_cmd_type c;
            c = pending_cmds.pop_front();
            if (rsp.steer_angle !== c.steer) begin
               $error("steer_angle expected %0d got %0d", c.steer, rsp.steer_angle);
               errors++;
            end
            if (rsp.target_index !== c.index) begin
               $error("target_index expected %0d got %0d", c.index, rsp.target_index);
               errors++;
            end
            if (rsp.empty_path !== c.empty) begin
               $error("empty_path expected %0d got %0d", c.empty, rsp.empty_path);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || done || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || csr_psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      steer_row_type dir[$];
      steer_row_type r;
      int plen;
      mdl_gain = 16'd256; mdl_len = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty path after reset, then extremes
      r = mk(OP_STEER, 0, 8388607, -8388608, 25736, 32767);
      r.typed = 1'b1; r.exp_empty = 1'b1;
      dir = {dir, r};
      dir = {dir, mk(OP_WRITE, 0, 0, 0, 0, 0)};
      dir = {dir, mk(OP_WRITE, 1, 8388607, 8388607, 25736, 0)};
      dir = {dir, mk(OP_WRITE, 2, -8388608, -8388608, -25736, -1)};
      dir = {dir, mk(OP_WRITE, 3, 0, 0, 8192, 0)};
      dir = {dir, mk(OP_WRITE, 1023, -1, 1, -25736, 0)};
      foreach (dir[i]) send_item(dir[i], 1'b0);
      dir.delete();
      drain_and_settle();
      csr_write(REG_PATH_LEN, 32'd4);
      dir = {dir, mk(OP_STEER, 0, 0, 0, 0, 256)};
      dir = {dir, mk(OP_STEER, 0, 0, 0, 0, 0)};
      dir = {dir, mk(OP_STEER, 0, 8388607, 8388607, 25736, 32767)};
      dir = {dir, mk(OP_STEER, 0, -8388608, -8388608, -25736, -32768)};
      dir = {dir, mk(OP_STEER, 0, 1000, -500, 25736, -32768)};
      dir = {dir, mk(OP_STEER, 0, -3000, 4000, -25736, -5)};
      dir = {dir, mk(OP_STEER, 0, 100, 100, 0, 0)};
      foreach (dir[i]) send_item(dir[i], 1'b0);
      dir.delete();
      drain_and_settle();
      csr_write(REG_GAIN, 32'd65535);
      csr_write(REG_PATH_LEN, FILL_PTS);
      // fill the searched part of the store so every scan reads written entries
      for (int i = 0; i < FILL_PTS; i++)
         send_item(mk(OP_WRITE, i, rnd_pos(8388607), rnd_pos(8388607),
                      $urandom_range(0, 51472) - 25736, $urandom), 1'b0);
      send_item(mk(OP_STEER, 0, rnd_pos(8388607), rnd_pos(8388607), 0, 1000), 1'b0);
      send_item(mk(OP_STEER, 0, 0, 0, -25736, -32768), 1'b0);
      drain_and_settle();
      csr_write(REG_GAIN, 32'd0);
      send_item(mk(OP_STEER, 0, 5, -5, 25736, 0), 1'b0);
      drain_and_settle();

      // random: short paths, with a gain change per phase
      for (int ph = 0; ph < 18; ph++) begin
         int span;
         csr_write(REG_GAIN, ph == 17 ? 32'd1 : $urandom_range(0, 65535));
         plen = $urandom_range(1, 24);
         csr_write(REG_PATH_LEN, plen);
         rsp_stall_en = (ph < 15);
         span = (ph % 3 == 0) ? 8388607 : 20000;
         for (int k = 0; k < 25; k++) begin
            if ($urandom_range(0, 3) == 0)
               r = mk(OP_WRITE, $urandom_range(0, 1023), rnd_pos(span), rnd_pos(span),
                      $urandom_range(0, 51472) - 25736, $urandom);
            else begin
               r = mk(OP_STEER, $urandom, rnd_pos(span), rnd_pos(span),
                      $urandom_range(0, 51472) - 25736, $urandom);
               if ($urandom_range(0, 7) == 0) r.speed = 0;
            end
            if (ph == 4 && k == 2) begin
               fork
                  begin
                     hold_long = 1'b1;
                     repeat (3000) @(posedge clock);
                     hold_long = 1'b0;
                  end
               join_none
            end
            send_item(r, ph < 15);
         end
         drain_and_settle();
      end

      done = 1'b1;
      $display("covered %0d path writes, %0d steering requests (%0d on an empty path)",
               n_write, n_steer, n_empty);
      $display("gain swept incl. zero, one and full scale, with output stalls and gaps");
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

// File: files.f
sv/ssc_pkg.sv
sv/ssc_req_if.sv
sv/ssc_rsp_if.sv
sv/ssc_path_store.sv
sv/ssc_isqrt.sv
sv/ssc_cordic.sv
sv/stanley_steering_controller_unit.sv
tb/tb_stanley_steering_controller_unit.sv
